### hdl/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants
// Beat formats, operation and status codes, and controller/datapath
// command and status bundles for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DEPTH_DEF  = 16;
  localparam int unsigned LIST_LIMIT = 16;  // most entries one listing reports
  localparam int unsigned POS_W      = 8;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_SORT       = 3'd4,
    KIND_LIST_FWD   = 3'd5,
    KIND_LIST_BWD   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BEYOND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [15:0] key;
    logic [15:0]       tag;
    logic [POS_W-1:0]  position;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] entry_key;
    logic [15:0]       entry_tag;
    status_e           status;
    logic              last;
  } out_beat_t;

  typedef struct packed {
    logic signed [15:0] key;
    logic [15:0]       tag;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LIST_RD,
    S_ENTRY_EMIT,
    S_SORT_START,
    S_SORT_FIRST,
    S_SORT_STEP,
    S_SORT_TAIL,
    S_EMIT_OK
  } state_e;

  // read address: logical position relative to the front
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_BACK,
    RD_IDX,
    RD_IDX1,
    RD_IDX2
  } rd_sel_e;

  typedef enum logic [1:0] {
    WS_NEW_FRONT,
    WS_BACK,
    WS_IDX
  } wr_sel_e;

  typedef enum logic [1:0] {
    WD_INPUT,
    WD_SORT,
    WD_CARRY
  } wd_sel_e;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    wd_sel_e wd_sel;
    logic    front_dec;
    logic    front_inc;
    logic    count_inc;
    logic    count_dec;
    logic    idx_zero;
    logic    idx_start;
    logic    idx_step;
    logic    limit_load;
    logic    limit_dec;
    logic    rem_load;
    logic    rem_dec;
    logic    swap_clr;
    logic    carry_load;
    logic    sort_step;
    logic    emit;
    logic    emit_rd;
    status_e emit_status;
    logic    emit_last;
  } ctl_t;

  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  empty;
    logic  sort_trivial;
    logic  beyond;
    logic  pass_end;
    logic  sort_again;
    logic  rem_last;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

### hdl/bdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### hdl/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl: operation sequencer
// Decodes each captured beat and steps the datapath through pushes, pops,
// bubble-sort passes and listings.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
          if (sts_i.kind inside {KIND_POP_FRONT, KIND_POP_BACK}) begin
            if (!sts_i.empty) state_d = S_ENTRY_EMIT;
          end else if (sts_i.kind == KIND_SORT) begin
            if (!sts_i.sort_trivial) state_d = S_SORT_START;
          end else if (sts_i.kind inside {KIND_LIST_FWD, KIND_LIST_BWD}) begin
            if (!sts_i.empty && !sts_i.beyond) state_d = S_LIST_RD;
          end
        end
      end
      S_LIST_RD:    state_d = S_ENTRY_EMIT;
      S_ENTRY_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.rem_last ? S_IDLE : S_LIST_RD;
      end
      S_SORT_START: state_d = S_SORT_FIRST;
      S_SORT_FIRST: state_d = S_SORT_STEP;
      S_SORT_STEP: begin
        if (sts_i.pass_end) state_d = S_SORT_TAIL;
      end
      S_SORT_TAIL:  state_d = sts_i.sort_again ? S_SORT_START : S_EMIT_OK;
      S_EMIT_OK: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default:      state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    ctl_o             = '0;
    ctl_o.rd_sel      = RD_ZERO;
    ctl_o.wr_sel      = WS_IDX;
    ctl_o.wd_sel      = WD_INPUT;
    ctl_o.emit_status = ST_OK;
    ctl_o.emit_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        ctl_o.capture = in_valid_i;
      end
      S_DECODE: begin
        if (sts_i.out_free) begin
          case (sts_i.kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              ctl_o.emit = 1'b1;
              if (sts_i.full) begin
                ctl_o.emit_status = ST_FULL;
              end else begin
                ctl_o.wr_en     = 1'b1;
                ctl_o.wr_sel    = (sts_i.kind == KIND_PUSH_FRONT) ? WS_NEW_FRONT : WS_BACK;
                ctl_o.front_dec = (sts_i.kind == KIND_PUSH_FRONT);
                ctl_o.count_inc = 1'b1;
              end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
              if (sts_i.empty) begin
                ctl_o.emit        = 1'b1;
                ctl_o.emit_status = ST_EMPTY;
              end else begin
                ctl_o.rd_en     = 1'b1;
                ctl_o.rd_sel    = (sts_i.kind == KIND_POP_FRONT) ? RD_ZERO : RD_BACK;
                ctl_o.front_inc = (sts_i.kind == KIND_POP_FRONT);
                ctl_o.count_dec = 1'b1;
                ctl_o.rem_load  = 1'b1;
              end
            end
            KIND_SORT: begin
              if (sts_i.sort_trivial) ctl_o.emit = 1'b1;
              else                    ctl_o.limit_load = 1'b1;
            end
            KIND_LIST_FWD, KIND_LIST_BWD: begin
              if (sts_i.empty) begin
                ctl_o.emit        = 1'b1;
                ctl_o.emit_status = ST_EMPTY;
              end else if (sts_i.beyond) begin
                ctl_o.emit        = 1'b1;
                ctl_o.emit_status = ST_BEYOND;
              end else begin
                ctl_o.idx_start = 1'b1;
                ctl_o.rem_load  = 1'b1;
              end
            end
            default: begin
              ctl_o.emit = 1'b1;
            end
          endcase
        end
      end
      S_LIST_RD: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = RD_IDX;
      end
      S_ENTRY_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.emit      = 1'b1;
          ctl_o.emit_rd   = 1'b1;
          ctl_o.emit_last = sts_i.rem_last;
          ctl_o.rem_dec   = 1'b1;
          ctl_o.idx_step  = 1'b1;
        end
      end
      S_SORT_START: begin
        ctl_o.rd_en    = 1'b1;
        ctl_o.rd_sel   = RD_ZERO;
        ctl_o.idx_zero = 1'b1;
        ctl_o.swap_clr = 1'b1;
      end
      S_SORT_FIRST: begin
        ctl_o.carry_load = 1'b1;
        ctl_o.rd_en      = 1'b1;
        ctl_o.rd_sel     = RD_IDX1;
      end
      S_SORT_STEP: begin
        ctl_o.wr_en     = 1'b1;
        ctl_o.wr_sel    = WS_IDX;
        ctl_o.wd_sel    = WD_SORT;
        ctl_o.sort_step = 1'b1;
        ctl_o.idx_step  = 1'b1;
        ctl_o.rd_en     = !sts_i.pass_end;
        ctl_o.rd_sel    = RD_IDX2;
      end
      S_SORT_TAIL: begin
        ctl_o.wr_en     = 1'b1;
        ctl_o.wr_sel    = WS_IDX;
        ctl_o.wd_sel    = WD_CARRY;
        ctl_o.limit_dec = 1'b1;
      end
      S_EMIT_OK: begin
        ctl_o.emit = sts_i.out_free;
      end
      default: begin
        ctl_o.emit = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/bdq_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dpath: deque datapath
// Circular entry store, front/count pointers, sort and listing counters,
// and the result register.
// ----------------------------------------------------------------------------
module bdq_dpath import bdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_beat_t  in_data_i,
  input  wire ctl_t      ctl_i,
  output sts_t           sts_o,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output out_beat_t      out_data_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned NW   = $clog2(LIST_LIMIT + 1);

  in_beat_t        op_q;
  logic [AW-1:0]   front_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   idx_q;
  logic [CW-1:0]   limit_q;
  logic [NW-1:0]   rem_q;
  entry_t          carry_q;
  logic            swapped_q;
  out_beat_t       out_q;
  logic            out_valid_q;

  kind_e           kind;
  logic [AW-1:0]   front_dec_val;
  logic [AW-1:0]   front_inc_val;
  logic [CW-1:0]   rd_log;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_entry;
  logic [$bits(entry_t)-1:0] rd_raw;
  entry_t          rd_entry;
  logic            gt;
  logic [POS_W-1:0] start;
  logic            beyond;
  logic [CMPW-1:0] n_raw;
  logic [NW-1:0]   n_list;
  logic            out_free;
  logic            bwd;

  // logical position -> physical slot; sum stays below twice DEPTH
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                            input logic [CW-1:0] logical);
    logic [SW-1:0] sum;
    sum = SW'(front) + SW'(logical);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  assign kind          = kind_e'(op_q.kind);
  assign bwd           = (kind == KIND_LIST_BWD);
  assign front_dec_val = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc_val = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

  always_comb begin
    case (ctl_i.rd_sel)
      RD_ZERO: rd_log = '0;
      RD_BACK: rd_log = count_q - CW'(1);
      RD_IDX:  rd_log = idx_q;
      RD_IDX1: rd_log = idx_q + CW'(1);
      RD_IDX2: rd_log = idx_q + CW'(2);
      default: rd_log = '0;
    endcase
  end
  assign rd_addr = slot_of(front_q, rd_log);

  always_comb begin
    case (ctl_i.wr_sel)
      WS_NEW_FRONT: wr_addr = front_dec_val;
      WS_BACK:      wr_addr = slot_of(front_q, count_q);
      WS_IDX:       wr_addr = slot_of(front_q, idx_q);
      default:      wr_addr = '0;
    endcase
  end

  assign rd_entry = entry_t'(rd_raw);
  assign gt       = (carry_q.key > rd_entry.key);

  // bubble step: the larger key moves on in the carry register
  always_comb begin
    case (ctl_i.wd_sel)
      WD_INPUT: wr_entry = '{key: op_q.key, tag: op_q.tag};
      WD_SORT:  wr_entry = gt ? rd_entry : carry_q;
      WD_CARRY: wr_entry = carry_q;
      default:  wr_entry = carry_q;
    endcase
  end

  bdq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .re_i    (ctl_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_raw)
  );

  // listing bounds
  assign start  = (op_q.position == '0) ? '0 : op_q.position - POS_W'(1);
  assign beyond = (CMPW'(start) >= CMPW'(count_q));
  assign n_raw  = bwd ? CMPW'(start) + CMPW'(1) : CMPW'(count_q) - CMPW'(start);
  assign n_list = (n_raw > CMPW'(LIST_LIMIT)) ? NW'(LIST_LIMIT) : NW'(n_raw);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.kind         = kind;
    sts_o.full         = (count_q == CW'(DEPTH));
    sts_o.empty        = (count_q == '0);
    sts_o.sort_trivial = (count_q <= CW'(1));
    sts_o.beyond       = beyond;
    sts_o.pass_end     = ((SW'(idx_q) + SW'(2)) == SW'(limit_q));
    sts_o.sort_again   = swapped_q && (limit_q > CW'(2));
    sts_o.rem_last     = (rem_q == NW'(1));
    sts_o.out_free     = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.front_dec) front_q <= front_dec_val;
      if (ctl_i.front_inc) front_q <= front_inc_val;
      if (ctl_i.count_inc) count_q <= count_q + CW'(1);
      if (ctl_i.count_dec) count_q <= count_q - CW'(1);
      if (ctl_i.emit)        out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) op_q <= in_data_i;
    if (ctl_i.idx_zero)       idx_q <= '0;
    else if (ctl_i.idx_start) idx_q <= CW'(start);
    else if (ctl_i.idx_step)  idx_q <= bwd ? idx_q - CW'(1) : idx_q + CW'(1);
    if (ctl_i.limit_load)     limit_q <= count_q;
    else if (ctl_i.limit_dec) limit_q <= limit_q - CW'(1);
    if (ctl_i.rem_load)     rem_q <= (bwd || kind == KIND_LIST_FWD) ? n_list : NW'(1);
    else if (ctl_i.rem_dec) rem_q <= rem_q - NW'(1);
    if (ctl_i.swap_clr)       swapped_q <= 1'b0;
    else if (ctl_i.sort_step) swapped_q <= swapped_q | gt;
    if (ctl_i.carry_load)                carry_q <= rd_entry;
    else if (ctl_i.sort_step && !gt)     carry_q <= rd_entry;
    if (ctl_i.emit) begin
      out_q.entry_key <= ctl_i.emit_rd ? rd_entry.key : '0;
      out_q.entry_tag <= ctl_i.emit_rd ? rd_entry.tag : '0;
      out_q.status    <= ctl_i.emit_status;
      out_q.last      <= ctl_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### hdl/bounded_deque_with_sort_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: push, error and no-op results are registered in decode, and a pop
//   emits its entry from the entry-emit state; a listing alternates read and
//   emit states per entry, and each emit waits out a stalled result. One beat
//   in work at a time; sort passes are paced by the single RAM read port.
// Reset: rst_ni clears the front pointer, entry count, controller and result
//   valid; the entry RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// bounded_deque_with_sort_core: bounded double-ended queue with stable sort
// Circular store of key/tag entries with push/pop at both ends, in-place
// bubble sort by signed key, and listings from a 1-based position.
// ----------------------------------------------------------------------------
module bounded_deque_with_sort_core import bdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  // request beats
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_beat_t in_data_i,
  // result beats
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_beat_t     out_data_o
);

  // The controller and datapath talk only through these two bundles.
  ctl_t ctl;
  sts_t sts;

  // Sequencer: a beat is taken only in the idle state; the result register
  // in the datapath lets the next beat enter while a result still waits.
  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Datapath: RAM with one write and one registered read port. Sorting keeps
  // the running maximum in a carry register so each compare needs one read.
  bdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### hdl/bdq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_checker: port-level checks
// Watches the deque's ports for result formatting and handshake sequencing.
// ----------------------------------------------------------------------------
module bdq_checker import bdq_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_beat_t out_data_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // error results are single, final and carry no entry
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL || out_data_o.status == ST_EMPTY ||
                    out_data_o.status == ST_BEYOND)
    |-> out_data_o.last && out_data_o.entry_key == '0 && out_data_o.entry_tag == '0)
    else $error("error result malformed");

  // one request in work at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // a request taken from idle while no result is pending gives no result in the cycle after it is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind bounded_deque_with_sort_core bdq_checker u_bdq_checker (.*);
`default_nettype wire

### sim/bounded_deque_with_sort_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_sort_core_tb: self-checking bench for the deque core
// Directed corner beats on an empty and a small deque, then random phases
// that grow the deque to full and shrink it to empty. The bench keeps its own
// copy of the deque, predicts every result beat and checks each one in order.
// Random stalls hit both sides, and one long receiver hold-off backs up input.
// ----------------------------------------------------------------------------
module bounded_deque_with_sort_core_tb;
  import bdq_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam logic [2:0]  KIND_UNUSED  = 3'd7;   // no operation, one zero result
  localparam int unsigned RANDOM_REQS  = 250;
  localparam int unsigned CALM_TAIL    = 40;     // last requests run without idling
  localparam int unsigned HOLD_AT_REQ  = 60;     // long hold-off starts here
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  bounded_deque_with_sort_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // single reset at the start of the run
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Shadow deque: circular store, front slot and live count, mirrored from
  // each accepted request beat. Result beats it predicts go to result_q.
  // --------------------------------------------------------------------------
  entry_t      shadow_mem [DEPTH];
  int unsigned head_slot = 0;
  int unsigned live_n    = 0;
  out_beat_t   result_q [$];

  function automatic int unsigned slot_at(int unsigned pos);
    return (head_slot + pos) % DEPTH;
  endfunction

  function automatic void add_result(logic [15:0] k, logic [15:0] t, status_e st, logic fin);
    out_beat_t b;
    b.entry_key = k;
    b.entry_tag = t;
    b.status    = st;
    b.last      = fin;
    result_q.push_back(b);
  endfunction

  function automatic void apply_request(in_beat_t req);
    int unsigned s;
    int unsigned start;
    int unsigned n;
    int unsigned lim;
    logic        fwd;
    logic        swapped;
    entry_t      tmp;
    case (req.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (live_n >= DEPTH) begin
          add_result('0, '0, ST_FULL, 1'b1);
        end else begin
          if (req.kind == KIND_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            s = head_slot;
          end else begin
            s = slot_at(live_n);
          end
          shadow_mem[s].key = req.key;
          shadow_mem[s].tag = req.tag;
          live_n++;
          add_result('0, '0, ST_OK, 1'b1);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (live_n == 0) begin
          add_result('0, '0, ST_EMPTY, 1'b1);
        end else begin
          if (req.kind == KIND_POP_FRONT) begin
            s = head_slot;
            head_slot = slot_at(1);
          end else begin
            s = slot_at(live_n - 1);
          end
          live_n--;
          add_result(shadow_mem[s].key, shadow_mem[s].tag, ST_OK, 1'b1);
        end
      end
      KIND_SORT: begin
        // bubble sort, swap only on strictly greater so equal keys keep order
        lim = live_n;
        swapped = 1'b1;
        while (swapped && lim > 1) begin
          swapped = 1'b0;
          for (int i = 0; i + 1 < lim; i++) begin
            if ($signed(shadow_mem[slot_at(i)].key) > $signed(shadow_mem[slot_at(i + 1)].key)) begin
              tmp = shadow_mem[slot_at(i)];
              shadow_mem[slot_at(i)] = shadow_mem[slot_at(i + 1)];
              shadow_mem[slot_at(i + 1)] = tmp;
              swapped = 1'b1;
            end
          end
          lim--;
        end
        add_result('0, '0, ST_OK, 1'b1);
      end
      KIND_LIST_FWD, KIND_LIST_BWD: begin
        fwd = (req.kind == KIND_LIST_FWD);
        start = (req.position == 0) ? 0 : req.position - 1;
        if (live_n == 0) begin
          add_result('0, '0, ST_EMPTY, 1'b1);
        end else if (start >= live_n) begin
          add_result('0, '0, ST_BEYOND, 1'b1);
        end else begin
          n = fwd ? live_n - start : start + 1;
          if (n > LIST_LIMIT) n = LIST_LIMIT;
          for (int i = 0; i < n; i++) begin
            s = slot_at(fwd ? start + i : start - i);
            add_result(shadow_mem[s].key, shadow_mem[s].tag, ST_OK, (i + 1 == n));
          end
        end
      end
      default: add_result('0, '0, ST_OK, 1'b1);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: directed corners first, then random grow/shrink phases.
  // stim_level tracks the live count so positions land near the live range.
  // --------------------------------------------------------------------------
  in_beat_t    pending_q [$];
  int unsigned stim_level = 0;

  task automatic add_req(logic [2:0] k, logic [15:0] key, logic [15:0] tag, logic [7:0] pos);
    in_beat_t r;
    r.kind     = k;
    r.key      = key;
    r.tag      = tag;
    r.position = pos;
    pending_q.push_back(r);
    if (k == KIND_PUSH_FRONT || k == KIND_PUSH_BACK) begin
      if (stim_level < DEPTH) stim_level++;
    end else if (k == KIND_POP_FRONT || k == KIND_POP_BACK) begin
      if (stim_level > 0) stim_level--;
    end
  endtask

  initial begin
    int unsigned taken;
    int unsigned phase_left;
    int unsigned pick;
    logic        grow;
    logic [2:0]  k;
    logic [15:0] key;
    logic [7:0]  pos;

    // everything on an empty deque
    add_req(KIND_POP_FRONT, 16'h0000, 16'h0000, 8'd0);
    add_req(KIND_POP_BACK,  16'hFFFF, 16'hFFFF, 8'hFF);
    add_req(KIND_LIST_FWD,  16'h0000, 16'h0000, 8'd0);
    add_req(KIND_LIST_BWD,  16'h0000, 16'h0000, 8'd1);
    add_req(KIND_SORT,      16'h0000, 16'h0000, 8'd0);
    add_req(KIND_UNUSED,    16'h0000, 16'h0000, 8'd0);
    // extreme keys and tags, a duplicate key to show sort stability
    add_req(KIND_PUSH_FRONT, 16'h8000, 16'h0000, 8'd0);
    add_req(KIND_PUSH_BACK,  16'h7FFF, 16'hFFFF, 8'd0);
    add_req(KIND_PUSH_FRONT, 16'h0000, 16'h0001, 8'd0);
    add_req(KIND_PUSH_BACK,  16'hFFFF, 16'h0002, 8'd0);
    add_req(KIND_PUSH_BACK,  16'h0000, 16'h0003, 8'd0);
    // listings: position 0 and 1 alike, last entry, one past, far past
    add_req(KIND_LIST_FWD, 16'h0000, 16'h0000, 8'd0);
    add_req(KIND_LIST_FWD, 16'h0000, 16'h0000, 8'd1);
    add_req(KIND_LIST_FWD, 16'h0000, 16'h0000, 8'd5);
    add_req(KIND_LIST_FWD, 16'h0000, 16'h0000, 8'd6);
    add_req(KIND_LIST_FWD, 16'h0000, 16'h0000, 8'd255);
    add_req(KIND_LIST_BWD, 16'h0000, 16'h0000, 8'd5);
    add_req(KIND_LIST_BWD, 16'h0000, 16'h0000, 8'd2);
    add_req(KIND_LIST_BWD, 16'h0000, 16'h0000, 8'd0);
    add_req(KIND_SORT,     16'h0000, 16'h0000, 8'd0);
    add_req(KIND_LIST_FWD, 16'h0000, 16'h0000, 8'd0);
    add_req(KIND_POP_FRONT, 16'h0000, 16'h0000, 8'd0);
    add_req(KIND_POP_BACK,  16'h0000, 16'h0000, 8'd0);
    add_req(KIND_UNUSED,    16'hFFFF, 16'hFFFF, 8'hFF);

    // random part: alternate phases biased toward pushes or pops so the
    // deque keeps hitting both full and empty
    taken = 0;
    phase_left = 0;
    grow = 1'b0;
    while (taken < RANDOM_REQS) begin
      if (phase_left == 0) begin
        grow = !grow;
        phase_left = $urandom_range(18, 40);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        k = KIND_UNUSED;
      end else if (pick < 10) begin
        k = KIND_SORT;
      end else if (pick < 26) begin
        k = $urandom_range(0, 1) ? KIND_LIST_FWD : KIND_LIST_BWD;
      end else if ((pick < 40) == grow) begin
        k = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
      end else begin
        k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      end
      // narrow keys make duplicates common for the sort
      if ($urandom_range(0, 3) == 0) begin
        key = $urandom_range(0, 4);
        key = key - 16'd2;
      end else begin
        key = $urandom_range(0, 65535);
      end
      if ((k == KIND_LIST_FWD || k == KIND_LIST_BWD) && $urandom_range(0, 7) != 0)
        pos = $urandom_range(0, stim_level + 1);
      else
        pos = $urandom_range(0, 255);
      add_req(k, key, $urandom_range(0, 65535), pos);
      if (k != KIND_UNUSED) taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offers beats from pending_q, idles in short bursts except in the
  // tail of the run. A beat is predicted at the edge where it is accepted.
  // --------------------------------------------------------------------------
  int unsigned src_gap   = 0;
  int unsigned reqs_in   = 0;
  int unsigned sorts_run = 0;
  logic        calm      = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(in_data);
        reqs_in <= reqs_in + 1;
        if (in_data.kind == KIND_SORT) sorts_run <= sorts_run + 1;
      end
      calm <= (pending_q.size() < CALM_TAIL);
      // a stalled beat stays as it is
      if (!in_valid || !in_stall) begin
        if (src_gap != 0) begin
          src_gap  <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          src_gap  <= $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // long receiver hold-off: sender keeps offering, so the core backs up
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && reqs_in == HOLD_AT_REQ) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result beat against the oldest prediction
  // and drives the receiver stall.
  // --------------------------------------------------------------------------
  int unsigned sink_gap    = 0;
  int unsigned beats_out   = 0;
  int unsigned mismatch_n  = 0;
  int unsigned full_seen   = 0;
  int unsigned empty_seen  = 0;
  int unsigned beyond_seen = 0;

  function automatic void check_result(out_beat_t got);
    out_beat_t want;
    if (result_q.size() == 0) begin
      mismatch_n++;
      if (mismatch_n <= 10)
        $display("%0t: unexpected result beat key %0d tag %h status %s last %b", $realtime,
                 $signed(got.entry_key), got.entry_tag, got.status.name(), got.last);
      return;
    end
    want = result_q.pop_front();
    if (got.entry_key !== want.entry_key || got.entry_tag !== want.entry_tag ||
        got.status !== want.status || got.last !== want.last) begin
      mismatch_n++;
      if (mismatch_n <= 10)
        $display("%0t: result mismatch: key %0d/%0d tag %h/%h status %s/%s last %b/%b",
                 $realtime, $signed(want.entry_key), $signed(got.entry_key), want.entry_tag,
                 got.entry_tag, want.status.name(), got.status.name(), want.last, got.last);
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      sink_gap  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        beats_out <= beats_out + 1;
        case (out_data.status)
          ST_FULL:   full_seen   <= full_seen + 1;
          ST_EMPTY:  empty_seen  <= empty_seen + 1;
          ST_BEYOND: beyond_seen <= beyond_seen + 1;
          default: ;
        endcase
      end
      if (sink_gap != 0) begin
        sink_gap  <= sink_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sink_gap  <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= (hold_left != 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run control: cycle-count watchdog and end-of-run verdict
  // --------------------------------------------------------------------------
  int unsigned cycle_n = 0;

  always @(posedge clk_i) cycle_n <= cycle_n + 1;

  initial begin
    while (cycle_n < CYCLE_LIMIT) @(posedge clk_i);
    $display("watchdog expired after %0d cycles, %0d result beats outstanding",
             cycle_n, result_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    while (rst_ni !== 1'b1) @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk_i);
    // let any stray beat show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests and %0d result beats, %0d sorts included.",
             reqs_in, beats_out, sorts_run);
    $display("Drops on full: %0d, empty replies: %0d, positions out of range: %0d.",
             full_seen, empty_seen, beyond_seen);
    if (mismatch_n == 0 && result_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d predictions left over", mismatch_n, result_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
